/* hdl/swdh_pkg.sv */
// ----------------------------------------------------------------------------
// swdh_pkg
// Shared types and constants for the SWD host transfer engine.
// ----------------------------------------------------------------------------
package swdh_pkg;

    localparam int LINE_RESET_BITS = 56;

    typedef logic [6:0] t_bit_idx;

    localparam logic [15:0] SELECT_SEQ       = 16'hE79E;
    localparam logic [7:0]  MAX_RETRIES_RST  = 8'd50;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_START      = 2'd1,
        OP_LINE_RESET = 2'd2,
        OP_UNUSED     = 2'd3
    } t_op;

    localparam logic [2:0] ACK_OK    = 3'h4;
    localparam logic [2:0] ACK_WAIT  = 3'h2;
    localparam logic [2:0] ACK_FAULT = 3'h1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_WAIT_EXH  = 3'd1;
    localparam logic [2:0] ST_FAULT     = 3'd2;
    localparam logic [2:0] ST_BAD_ACK   = 3'd3;
    localparam logic [2:0] ST_PARITY    = 3'd4;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_REQ        = 4'd1,
        PH_TURN_ACK   = 4'd2,
        PH_ACK        = 4'd3,
        PH_TURN_WR    = 4'd4,
        PH_WDATA      = 4'd5,
        PH_WPAR       = 4'd6,
        PH_RDATA      = 4'd7,
        PH_RPAR       = 4'd8,
        PH_TURN_END   = 4'd9,
        PH_TURN_RETRY = 4'd10,
        PH_LR_A       = 4'd11,
        PH_LR_B       = 4'd12
    } t_phase;

    typedef struct packed {
        logic [1:0]  operation;
        logic        ap_not_dp;
        logic        read_not_write;
        logic [1:0]  reg_addr;
        logic [31:0] write_data;
        logic        swdio_in;
    } t_item;

    typedef struct packed {
        logic        swdio_out;
        logic        swdio_oe;
        logic        clock_pulse;
        logic        busy_res;
        logic        done_res;
        logic [2:0]  ack_code;
        logic [2:0]  status;
        logic [31:0] read_data;
    } t_result;

endpackage

/* hdl/swdh_in_stage.sv */
// ----------------------------------------------------------------------------
// swdh_in_stage
// Input register: holds one accepted item until the engine consumes it.
// ----------------------------------------------------------------------------
module swdh_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  swdh_pkg::t_item i_item,
    output logic            o_valid,
    output swdh_pkg::t_item o_item,
    input  logic            i_take
);

    logic            r_valid;
    swdh_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

/* hdl/swdh_core.sv */
// ----------------------------------------------------------------------------
// swdh_core
// SWD protocol state machine: advances one SWCLK tick per item and forms
// the result from the updated state.
// ----------------------------------------------------------------------------
module swdh_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    input  logic              i_step,
    input  swdh_pkg::t_item   i_item,
    output swdh_pkg::t_result o_result
);

    swdh_pkg::t_phase   r_phase, n_phase;
    swdh_pkg::t_bit_idx r_bit_index, n_bit_index;
    logic [31:0]        r_shift_word, n_shift_word;
    logic [7:0]         r_request_byte, n_request_byte;
    logic [7:0]         r_retry_count, n_retry_count;
    logic [2:0]         r_ack_bits, n_ack_bits;
    logic               r_parity_acc, n_parity_acc;
    logic               r_is_read, n_is_read;
    logic [31:0]        r_held_write_word, n_held_write_word;
    logic [31:0]        r_received_word, n_received_word;
    logic [7:0]         r_max_wait_retries;

    logic               clk_pulse;
    logic               done;
    logic [2:0]         status;
    logic [2:0]         final_status;
    logic               req_parity;
    logic               dout;
    logic               doe;
    swdh_pkg::t_bit_idx seq_off;

    always_comb begin
        if (r_ack_bits == swdh_pkg::ACK_OK) begin
            final_status = (r_is_read && r_parity_acc) ? swdh_pkg::ST_PARITY
                                                       : swdh_pkg::ST_OK;
        end else if (r_ack_bits == swdh_pkg::ACK_WAIT) begin
            final_status = swdh_pkg::ST_WAIT_EXH;
        end else if (r_ack_bits == swdh_pkg::ACK_FAULT) begin
            final_status = swdh_pkg::ST_FAULT;
        end else begin
            final_status = swdh_pkg::ST_BAD_ACK;
        end
    end

    assign req_parity = i_item.ap_not_dp ^ i_item.read_not_write
                      ^ i_item.reg_addr[0] ^ i_item.reg_addr[1];

    // next state
    always_comb begin
        n_phase           = r_phase;
        n_bit_index       = r_bit_index;
        n_shift_word      = r_shift_word;
        n_request_byte    = r_request_byte;
        n_retry_count     = r_retry_count;
        n_ack_bits        = r_ack_bits;
        n_parity_acc      = r_parity_acc;
        n_is_read         = r_is_read;
        n_held_write_word = r_held_write_word;
        n_received_word   = r_received_word;
        clk_pulse         = 1'b1;
        done              = 1'b0;
        status            = swdh_pkg::ST_OK;

        unique case (r_phase)
            swdh_pkg::PH_IDLE: begin
                clk_pulse = 1'b0;
                if (i_item.operation == swdh_pkg::OP_START) begin
                    n_request_byte    = {1'b1, 1'b0, req_parity, i_item.reg_addr,
                                         i_item.read_not_write, i_item.ap_not_dp, 1'b1};
                    n_is_read         = i_item.read_not_write;
                    n_held_write_word = i_item.write_data;
                    n_retry_count     = '0;
                    n_ack_bits        = '0;
                    n_bit_index       = '0;
                    n_phase           = swdh_pkg::PH_REQ;
                end else if (i_item.operation == swdh_pkg::OP_LINE_RESET) begin
                    n_bit_index = '0;
                    n_phase     = swdh_pkg::PH_LR_A;
                end
            end
            swdh_pkg::PH_REQ: begin
                if (r_bit_index >= 7'd7) begin
                    n_phase     = swdh_pkg::PH_TURN_ACK;
                    n_bit_index = '0;
                end else begin
                    n_bit_index = r_bit_index + 7'd1;
                end
            end
            swdh_pkg::PH_TURN_ACK: begin
                n_phase     = swdh_pkg::PH_ACK;
                n_bit_index = '0;
            end
            swdh_pkg::PH_ACK: begin
                if (r_bit_index == 7'd0) begin
                    n_ack_bits = {i_item.swdio_in, 2'b00};
                end else if (r_bit_index == 7'd1) begin
                    n_ack_bits = r_ack_bits | {1'b0, i_item.swdio_in, 1'b0};
                end else if (r_bit_index == 7'd2) begin
                    n_ack_bits = r_ack_bits | {2'b00, i_item.swdio_in};
                end
                if (r_bit_index < 7'd2) begin
                    n_bit_index = r_bit_index + 7'd1;
                end else begin
                    n_bit_index = '0;
                    if (n_ack_bits == swdh_pkg::ACK_OK) begin
                        if (r_is_read) begin
                            n_phase      = swdh_pkg::PH_RDATA;
                            n_shift_word = '0;
                            n_parity_acc = 1'b0;
                        end else begin
                            n_phase = swdh_pkg::PH_TURN_WR;
                        end
                    end else if (n_ack_bits == swdh_pkg::ACK_WAIT
                                 && r_retry_count < r_max_wait_retries) begin
                        n_retry_count = r_retry_count + 8'd1;
                        n_phase       = swdh_pkg::PH_TURN_RETRY;
                    end else begin
                        n_phase = swdh_pkg::PH_TURN_END;
                    end
                end
            end
            swdh_pkg::PH_TURN_WR: begin
                n_phase      = swdh_pkg::PH_WDATA;
                n_bit_index  = '0;
                n_shift_word = r_held_write_word;
                n_parity_acc = ^r_held_write_word;
            end
            swdh_pkg::PH_WDATA: begin
                n_shift_word = {1'b0, r_shift_word[31:1]};
                if (r_bit_index >= 7'd31) begin
                    n_phase     = swdh_pkg::PH_WPAR;
                    n_bit_index = '0;
                end else begin
                    n_bit_index = r_bit_index + 7'd1;
                end
            end
            swdh_pkg::PH_WPAR: begin
                done        = 1'b1;
                status      = final_status;
                n_phase     = swdh_pkg::PH_IDLE;
                n_bit_index = '0;
            end
            swdh_pkg::PH_RDATA: begin
                n_shift_word = {i_item.swdio_in, r_shift_word[31:1]};
                n_parity_acc = r_parity_acc ^ i_item.swdio_in;
                if (r_bit_index >= 7'd31) begin
                    n_phase     = swdh_pkg::PH_RPAR;
                    n_bit_index = '0;
                end else begin
                    n_bit_index = r_bit_index + 7'd1;
                end
            end
            swdh_pkg::PH_RPAR: begin
                n_parity_acc    = r_parity_acc ^ i_item.swdio_in;
                n_received_word = r_shift_word;
                n_phase         = swdh_pkg::PH_TURN_END;
            end
            swdh_pkg::PH_TURN_END: begin
                done        = 1'b1;
                status      = final_status;
                n_phase     = swdh_pkg::PH_IDLE;
                n_bit_index = '0;
            end
            swdh_pkg::PH_TURN_RETRY: begin
                n_phase     = swdh_pkg::PH_REQ;
                n_bit_index = '0;
            end
            swdh_pkg::PH_LR_A: begin
                if (r_bit_index >= 7'(swdh_pkg::LINE_RESET_BITS + 15)) begin
                    n_phase     = swdh_pkg::PH_LR_B;
                    n_bit_index = '0;
                end else begin
                    n_bit_index = r_bit_index + 7'd1;
                end
            end
            swdh_pkg::PH_LR_B: begin
                if (r_bit_index >= 7'(swdh_pkg::LINE_RESET_BITS + 2)) begin
                    done        = 1'b1;
                    n_phase     = swdh_pkg::PH_IDLE;
                    n_bit_index = '0;
                end else begin
                    n_bit_index = r_bit_index + 7'd1;
                end
            end
            default: begin
                clk_pulse   = 1'b0;
                n_phase     = swdh_pkg::PH_IDLE;
                n_bit_index = '0;
            end
        endcase
    end

    assign seq_off = n_bit_index - 7'(swdh_pkg::LINE_RESET_BITS);

    // line drive for the next cycle
    always_comb begin
        dout = 1'b0;
        doe  = 1'b1;
        unique case (n_phase)
            swdh_pkg::PH_REQ: begin
                dout = n_request_byte[n_bit_index[2:0]];
            end
            swdh_pkg::PH_WDATA: begin
                dout = n_shift_word[0];
            end
            swdh_pkg::PH_WPAR: begin
                dout = n_parity_acc;
            end
            swdh_pkg::PH_LR_A: begin
                if (n_bit_index < 7'(swdh_pkg::LINE_RESET_BITS)) begin
                    dout = 1'b1;
                end else begin
                    dout = swdh_pkg::SELECT_SEQ[seq_off[3:0]];
                end
            end
            swdh_pkg::PH_LR_B: begin
                dout = (n_bit_index < 7'(swdh_pkg::LINE_RESET_BITS));
            end
            swdh_pkg::PH_TURN_ACK, swdh_pkg::PH_ACK, swdh_pkg::PH_TURN_WR,
            swdh_pkg::PH_RDATA, swdh_pkg::PH_RPAR, swdh_pkg::PH_TURN_END,
            swdh_pkg::PH_TURN_RETRY: begin
                doe = 1'b0;
            end
            default: begin
                dout = 1'b0;
                doe  = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_result.swdio_out   = dout;
        o_result.swdio_oe    = doe;
        o_result.clock_pulse = clk_pulse;
        o_result.busy_res    = (n_phase != swdh_pkg::PH_IDLE);
        o_result.done_res    = done;
        o_result.ack_code    = n_ack_bits;
        o_result.status      = status;
        o_result.read_data   = n_received_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_wait_retries <= swdh_pkg::MAX_RETRIES_RST;
        end else if (i_cfg_we) begin
            r_max_wait_retries <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= swdh_pkg::PH_IDLE;
            r_bit_index       <= '0;
            r_shift_word      <= '0;
            r_request_byte    <= '0;
            r_retry_count     <= '0;
            r_ack_bits        <= '0;
            r_parity_acc      <= 1'b0;
            r_is_read         <= 1'b0;
            r_held_write_word <= '0;
            r_received_word   <= '0;
        end else if (i_step) begin
            r_phase           <= n_phase;
            r_bit_index       <= n_bit_index;
            r_shift_word      <= n_shift_word;
            r_request_byte    <= n_request_byte;
            r_retry_count     <= n_retry_count;
            r_ack_bits        <= n_ack_bits;
            r_parity_acc      <= n_parity_acc;
            r_is_read         <= n_is_read;
            r_held_write_word <= n_held_write_word;
            r_received_word   <= n_received_word;
        end
    end

endmodule

/* hdl/swdh_out_stage.sv */
// ----------------------------------------------------------------------------
// swdh_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module swdh_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  swdh_pkg::t_result i_result,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output swdh_pkg::t_result o_result
);

    logic              r_valid;
    swdh_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* hdl/swd_host_transfer_engine_unit.sv */
// ----------------------------------------------------------------------------
// swd_host_transfer_engine_unit
// SWD host transfer engine: one item is one SWCLK tick; the engine walks
// request, ACK, data and line reset phases and reports one result per item.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input reg, then its result in the result reg.
// Throughput: 1 item per cycle while results are taken; the protocol state machine steps once per item.
// Reset (i_rst_n low, synchronous): both stages empty, engine idle, retry
// limit back to 50, received word cleared.
module swd_host_transfer_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic        i_ap_not_dp,
    input  logic        i_read_not_write,
    input  logic [1:0]  i_reg_addr,
    input  logic [31:0] i_write_data,
    input  logic        i_swdio_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_swdio_out,
    output logic        o_swdio_oe,
    output logic        o_clock_pulse,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [2:0]  o_ack_code,
    output logic [2:0]  o_status,
    output logic [31:0] o_read_data
);

    swdh_pkg::t_item   in_item;
    swdh_pkg::t_item   held_item;
    swdh_pkg::t_result core_result;
    swdh_pkg::t_result out_result;
    logic              held_valid;
    logic              can_load;
    logic              step;

    assign in_item.operation      = i_operation;
    assign in_item.ap_not_dp      = i_ap_not_dp;
    assign in_item.read_not_write = i_read_not_write;
    assign in_item.reg_addr       = i_reg_addr;
    assign in_item.write_data     = i_write_data;
    assign in_item.swdio_in       = i_swdio_in;

    assign step = held_valid && can_load;

    swdh_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .o_item  (held_item),
        .i_take  (step)
    );

    swdh_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_item      (held_item),
        .o_result    (core_result)
    );

    swdh_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (core_result),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_swdio_out   = out_result.swdio_out;
    assign o_swdio_oe    = out_result.swdio_oe;
    assign o_clock_pulse = out_result.clock_pulse;
    assign o_busy_res    = out_result.busy_res;
    assign o_done_res    = out_result.done_res;
    assign o_ack_code    = out_result.ack_code;
    assign o_status      = out_result.status;
    assign o_read_data   = out_result.read_data;

endmodule

/* bench/swd_engine_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swd_engine_checker
// Watches the item and result channels of the SWD host engine, steps its own
// model of the protocol state machine once per accepted item and compares
// every accepted result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module swd_engine_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_operation,
    input  logic        i_ap_not_dp,
    input  logic        i_read_not_write,
    input  logic [1:0]  i_reg_addr,
    input  logic [31:0] i_write_data,
    input  logic        i_swdio_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_swdio_out,
    input  logic        i_swdio_oe,
    input  logic        i_clock_pulse,
    input  logic        i_busy_res,
    input  logic        i_done_res,
    input  logic [2:0]  i_ack_code,
    input  logic [2:0]  i_status,
    input  logic [31:0] i_read_data,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_busy
);
    import swdh_pkg::*;

    t_phase      eng_phase;
    logic [6:0]  bit_idx;
    logic [31:0] shift_word;
    logic [7:0]  req_byte;
    logic [7:0]  retries;
    logic [2:0]  ack_bits;
    logic        par_acc;
    logic        is_rd;
    logic [31:0] held_word;
    logic [31:0] rx_word;
    logic [7:0]  wait_limit;

    t_result     tick_results[$];
    int          fails = 0;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        fails++;
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, field, got, want);
    endtask

    function automatic logic [2:0] end_status();
        if (ack_bits == ACK_OK)
            return (is_rd && par_acc) ? ST_PARITY : ST_OK;
        if (ack_bits == ACK_WAIT)
            return ST_WAIT_EXH;
        if (ack_bits == ACK_FAULT)
            return ST_FAULT;
        return ST_BAD_ACK;
    endfunction

    function automatic t_result step_engine(input t_item it);
        t_result    r;
        logic       par;
        logic [6:0] sel;
        r = '0;
        if (eng_phase == PH_IDLE) begin
            if (it.operation == OP_START) begin
                par = it.ap_not_dp ^ it.read_not_write ^ it.reg_addr[0] ^ it.reg_addr[1];
                // start, APnDP, RnW, A2, A3, parity, stop, park (LSB first)
                req_byte = {1'b1, 1'b0, par, it.reg_addr, it.read_not_write,
                            it.ap_not_dp, 1'b1};
                is_rd = it.read_not_write;
                held_word = it.write_data;
                retries = '0;
                ack_bits = '0;
                bit_idx = '0;
                eng_phase = PH_REQ;
            end else if (it.operation == OP_LINE_RESET) begin
                bit_idx = '0;
                eng_phase = PH_LR_A;
            end
        end else begin
            r.clock_pulse = 1'b1;
            case (eng_phase)
                PH_REQ: begin
                    if (bit_idx >= 7) begin
                        eng_phase = PH_TURN_ACK;
                        bit_idx = '0;
                    end else begin
                        bit_idx++;
                    end
                end
                PH_TURN_ACK: begin
                    eng_phase = PH_ACK;
                    bit_idx = '0;
                end
                PH_ACK: begin
                    if (bit_idx == 0)
                        ack_bits = {it.swdio_in, 2'b00};
                    else if (bit_idx == 1)
                        ack_bits[1] = it.swdio_in;
                    else
                        ack_bits[0] = it.swdio_in;
                    if (bit_idx < 2) begin
                        bit_idx++;
                    end else begin
                        bit_idx = '0;
                        if (ack_bits == ACK_OK) begin
                            if (is_rd) begin
                                eng_phase = PH_RDATA;
                                shift_word = '0;
                                par_acc = 1'b0;
                            end else begin
                                eng_phase = PH_TURN_WR;
                            end
                        end else if (ack_bits == ACK_WAIT && retries < wait_limit) begin
                            retries++;
                            eng_phase = PH_TURN_RETRY;
                        end else begin
                            eng_phase = PH_TURN_END;
                        end
                    end
                end
                PH_TURN_WR: begin
                    eng_phase = PH_WDATA;
                    bit_idx = '0;
                    shift_word = held_word;
                    par_acc = ^held_word;
                end
                PH_WDATA: begin
                    shift_word = shift_word >> 1;
                    if (bit_idx >= 31) begin
                        eng_phase = PH_WPAR;
                        bit_idx = '0;
                    end else begin
                        bit_idx++;
                    end
                end
                PH_WPAR, PH_TURN_END: begin
                    r.done_res = 1'b1;
                    r.status = end_status();
                    eng_phase = PH_IDLE;
                    bit_idx = '0;
                end
                PH_RDATA: begin
                    shift_word = {it.swdio_in, shift_word[31:1]};
                    par_acc ^= it.swdio_in;
                    if (bit_idx >= 31) begin
                        eng_phase = PH_RPAR;
                        bit_idx = '0;
                    end else begin
                        bit_idx++;
                    end
                end
                PH_RPAR: begin
                    par_acc ^= it.swdio_in;
                    rx_word = shift_word;
                    eng_phase = PH_TURN_END;
                end
                PH_TURN_RETRY: begin
                    eng_phase = PH_REQ;
                    bit_idx = '0;
                end
                PH_LR_A: begin
                    if (int'(bit_idx) + 1 >= LINE_RESET_BITS + 16) begin
                        eng_phase = PH_LR_B;
                        bit_idx = '0;
                    end else begin
                        bit_idx++;
                    end
                end
                PH_LR_B: begin
                    if (int'(bit_idx) + 1 >= LINE_RESET_BITS + 3) begin
                        r.done_res = 1'b1;
                        r.status = ST_OK;
                        eng_phase = PH_IDLE;
                        bit_idx = '0;
                    end else begin
                        bit_idx++;
                    end
                end
                default: begin
                    r.clock_pulse = 1'b0;
                    eng_phase = PH_IDLE;
                    bit_idx = '0;
                end
            endcase
        end

        // line level for the next wire cycle
        case (eng_phase)
            PH_REQ: begin
                r.swdio_oe = 1'b1;
                r.swdio_out = req_byte[bit_idx[2:0]];
            end
            PH_WDATA: begin
                r.swdio_oe = 1'b1;
                r.swdio_out = shift_word[0];
            end
            PH_WPAR: begin
                r.swdio_oe = 1'b1;
                r.swdio_out = par_acc;
            end
            PH_LR_A: begin
                r.swdio_oe = 1'b1;
                sel = bit_idx - 7'(LINE_RESET_BITS);
                r.swdio_out = (int'(bit_idx) < LINE_RESET_BITS) ? 1'b1
                                                                 : SELECT_SEQ[sel[3:0]];
            end
            PH_LR_B: begin
                r.swdio_oe = 1'b1;
                r.swdio_out = (int'(bit_idx) < LINE_RESET_BITS);
            end
            PH_TURN_ACK, PH_ACK, PH_TURN_WR, PH_RDATA, PH_RPAR, PH_TURN_END,
            PH_TURN_RETRY: begin
                r.swdio_oe = 1'b0;
                r.swdio_out = 1'b0;
            end
            default: begin
                r.swdio_oe = 1'b1;
                r.swdio_out = 1'b0;
            end
        endcase

        r.busy_res = (eng_phase != PH_IDLE);
        r.ack_code = ack_bits;
        r.read_data = rx_word;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_item   item;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            eng_phase = PH_IDLE;
            bit_idx = '0;
            shift_word = '0;
            req_byte = '0;
            retries = '0;
            ack_bits = '0;
            par_acc = 1'b0;
            is_rd = 1'b0;
            held_word = '0;
            rx_word = '0;
            wait_limit = MAX_RETRIES_RST;
            tick_results.delete();
        end else begin
            if (i_cfg_we)
                wait_limit = i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                item.operation = i_operation;
                item.ap_not_dp = i_ap_not_dp;
                item.read_not_write = i_read_not_write;
                item.reg_addr = i_reg_addr;
                item.write_data = i_write_data;
                item.swdio_in = i_swdio_in;
                tick_results.push_back(step_engine(item));
            end
            if (i_out_valid && i_out_ready) begin
                got.swdio_out = i_swdio_out;
                got.swdio_oe = i_swdio_oe;
                got.clock_pulse = i_clock_pulse;
                got.busy_res = i_busy_res;
                got.done_res = i_done_res;
                got.ack_code = i_ack_code;
                got.status = i_status;
                got.read_data = i_read_data;
                if (tick_results.size() == 0) begin
                    report_mismatch("result with no item outstanding", 32'h0, 32'h0);
                end else begin
                    want = tick_results.pop_front();
                    if (got.swdio_out !== want.swdio_out)
                        report_mismatch("swdio_out", got.swdio_out, want.swdio_out);
                    if (got.swdio_oe !== want.swdio_oe)
                        report_mismatch("swdio_oe", got.swdio_oe, want.swdio_oe);
                    if (got.clock_pulse !== want.clock_pulse)
                        report_mismatch("clock_pulse", got.clock_pulse, want.clock_pulse);
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", got.busy_res, want.busy_res);
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", got.done_res, want.done_res);
                    if (got.ack_code !== want.ack_code)
                        report_mismatch("ack_code", got.ack_code, want.ack_code);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", got.read_data, want.read_data);
                end
            end
        end
        o_pending = tick_results.size();
        o_busy = (eng_phase != PH_IDLE);
        o_fail_count = fails;
    end

endmodule

/* bench/tb_swd_host_transfer_engine_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_swd_host_transfer_engine_unit
// Drives the SWD host engine with directed transfers, line resets and WAIT
// retries, then random well-formed and broken tick sequences over several
// retry limits, with random stalls on both channels; the checker does the
// prediction and comparison, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_swd_host_transfer_engine_unit;
    import swdh_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 550;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation = '0;
    logic        i_ap_not_dp = 1'b0;
    logic        i_read_not_write = 1'b0;
    logic [1:0]  i_reg_addr = '0;
    logic [31:0] i_write_data = '0;
    logic        i_swdio_in = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_swdio_out;
    logic        o_swdio_oe;
    logic        o_clock_pulse;
    logic        o_busy_res;
    logic        o_done_res;
    logic [2:0]  o_ack_code;
    logic [2:0]  o_status;
    logic [31:0] o_read_data;

    int          fail_count;
    int          pending;
    logic        eng_busy;
    int          cycles = 0;
    int          items_sent = 0;
    logic [7:0]  wait_limit = MAX_RETRIES_RST;
    bit          steady_send = 1'b0;
    bit          steady_recv = 1'b1;
    int          stall_left = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    swd_host_transfer_engine_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_ap_not_dp      (i_ap_not_dp),
        .i_read_not_write (i_read_not_write),
        .i_reg_addr       (i_reg_addr),
        .i_write_data     (i_write_data),
        .i_swdio_in       (i_swdio_in),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_swdio_out      (o_swdio_out),
        .o_swdio_oe       (o_swdio_oe),
        .o_clock_pulse    (o_clock_pulse),
        .o_busy_res       (o_busy_res),
        .o_done_res       (o_done_res),
        .o_ack_code       (o_ack_code),
        .o_status         (o_status),
        .o_read_data      (o_read_data)
    );

    swd_engine_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_ap_not_dp      (i_ap_not_dp),
        .i_read_not_write (i_read_not_write),
        .i_reg_addr       (i_reg_addr),
        .i_write_data     (i_write_data),
        .i_swdio_in       (i_swdio_in),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_swdio_out      (o_swdio_out),
        .i_swdio_oe       (o_swdio_oe),
        .i_clock_pulse    (o_clock_pulse),
        .i_busy_res       (o_busy_res),
        .i_done_res       (o_done_res),
        .i_ack_code       (o_ack_code),
        .i_status         (o_status),
        .i_read_data      (o_read_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_busy           (eng_busy)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side backpressure: short and long stalls, calm stretches
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            steady_recv = !steady_recv;
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (steady_recv || $urandom_range(0, 99) < 65) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 2);
        end
    end

    // entered and left at a falling edge; valid stays up until the next call
    task automatic send_item(input t_op op, input logic apd, input logic rnw,
                             input logic [1:0] addr, input logic [31:0] wd,
                             input logic sin);
        int r;
        int gap;
        gap = 0;
        if ($urandom_range(0, 149) == 0)
            steady_send = !steady_send;
        if (!steady_send) begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                gap = $urandom_range(8, 30);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_ap_not_dp <= apd;
        i_read_not_write <= rnw;
        i_reg_addr <= addr;
        i_write_data <= wd;
        i_swdio_in <= sin;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic stop_items();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // tick during a sequence; now and then a command, which must be ignored
    task automatic busy_tick(input logic sin);
        t_op op;
        op = OP_TICK;
        if ($urandom_range(0, 7) == 0)
            op = t_op'($urandom_range(1, 3));
        send_item(op, 1'($urandom), 1'($urandom), 2'($urandom), $urandom, sin);
    endtask

    task automatic idle_tick(input t_op op);
        send_item(op, 1'($urandom), 1'($urandom), 2'($urandom), $urandom, 1'($urandom));
    endtask

    // waits: WAIT acks before the last one; last_ack WAIT means the limit ran out
    task automatic run_transfer(input logic apd, input logic rnw, input logic [1:0] addr,
                                input logic [31:0] wd, input logic [2:0] last_ack,
                                input int waits, input logic [31:0] rd,
                                input logic bad_par);
        logic [2:0] ack;
        send_item(OP_START, apd, rnw, addr, wd, 1'($urandom));
        for (int w = 0; w <= waits; w++) begin
            ack = (w < waits) ? ACK_WAIT : last_ack;
            repeat ((w == 0) ? 9 : 10) busy_tick(1'($urandom));
            for (int b = 2; b >= 0; b--)
                busy_tick(ack[b]);
        end
        if (last_ack == ACK_OK && rnw) begin
            for (int b = 0; b < 32; b++)
                busy_tick(rd[b]);
            busy_tick((^rd) ^ bad_par);
            busy_tick(1'($urandom));
        end else if (last_ack == ACK_OK) begin
            repeat (34) busy_tick(1'($urandom));
        end else begin
            busy_tick(1'($urandom));
        end
    endtask

    task automatic run_line_reset();
        idle_tick(OP_LINE_RESET);
        repeat (2 * LINE_RESET_BITS + 19) busy_tick(1'($urandom));
    endtask

    // a line held high reads as a bad ack, which ends a transfer quickly
    task automatic flush_engine();
        while (eng_busy)
            send_item(OP_TICK, 1'($urandom), 1'($urandom), 2'($urandom), $urandom, 1'b1);
    endtask

    task automatic set_wait_limit(input logic [7:0] v);
        stop_items();
        flush_engine();
        stop_items();
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        wait_limit = v;
    endtask

    task automatic random_sequence();
        int         r;
        int         sel;
        int         cap;
        int         waits;
        logic [2:0] last_ack;
        r = $urandom_range(0, 99);
        cap = (wait_limit < 3) ? int'(wait_limit) : 3;
        if (r < 72) begin
            sel = $urandom_range(0, 99);
            waits = $urandom_range(0, cap);
            if (sel < 55) begin
                last_ack = ACK_OK;
            end else if (sel < 68) begin
                if (wait_limit <= 4) begin
                    last_ack = ACK_WAIT;
                    waits = wait_limit;
                end else begin
                    last_ack = ACK_OK;
                end
            end else if (sel < 82) begin
                last_ack = ACK_FAULT;
            end else begin
                do last_ack = 3'($urandom);
                while (last_ack == ACK_OK || last_ack == ACK_WAIT || last_ack == ACK_FAULT);
            end
            run_transfer(1'($urandom), 1'($urandom), 2'($urandom), $urandom, last_ack,
                         waits, $urandom, $urandom_range(0, 7) == 0);
        end else if (r < 76) begin
            run_line_reset();
        end else if (r < 90) begin
            repeat ($urandom_range(1, 5))
                idle_tick($urandom_range(0, 1) ? OP_UNUSED : OP_TICK);
        end else begin
            // cut-short transfer: random items after the start, then drain
            idle_tick(OP_START);
            repeat ($urandom_range(1, 40))
                idle_tick(t_op'($urandom_range(0, 3)));
            flush_engine();
        end
    endtask

    initial begin
        int         phase_end;
        logic [7:0] lim;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_tick(OP_UNUSED);
        idle_tick(OP_TICK);
        run_transfer(1'b0, 1'b0, 2'd0, 32'h0000_0000, ACK_OK, 0, 32'h0, 1'b0);
        run_transfer(1'b1, 1'b0, 2'd3, 32'hFFFF_FFFF, ACK_OK, 0, 32'h0, 1'b0);
        run_transfer(1'b1, 1'b1, 2'd2, 32'h0, ACK_OK, 0, 32'hFFFF_FFFF, 1'b0);
        run_transfer(1'b0, 1'b1, 2'd1, 32'h0, ACK_OK, 0, 32'h8000_0001, 1'b1);
        run_transfer(1'b1, 1'b1, 2'd1, 32'h0, ACK_FAULT, 0, 32'h0, 1'b0);
        run_transfer(1'b0, 1'b0, 2'd2, 32'h1234_5678, 3'b111, 0, 32'h0, 1'b0);
        run_transfer(1'b1, 1'b0, 2'd1, 32'h5555_AAAA, 3'b000, 0, 32'h0, 1'b0);
        run_transfer(1'b0, 1'b1, 2'd3, 32'h0, ACK_OK, 2, 32'hA5A5_0F0F, 1'b0);
        run_line_reset();
        set_wait_limit(8'd0);
        run_transfer(1'b1, 1'b1, 2'd0, 32'h0, ACK_WAIT, 0, 32'h0, 1'b0);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       lim = 8'd1;
                1:       lim = 8'd255;
                2:       lim = 8'd3;
                3:       lim = 8'd0;
                default: lim = 8'($urandom);
            endcase
            set_wait_limit(lim);
            phase_end = items_sent + RANDOM_ITEMS / 5;
            while (items_sent < phase_end)
                random_sequence();
        end

        stop_items();
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
